// ----- design/cqc_pkg.sv -----
// cqc_pkg: shared constants and types for the consensus quality classifier.
// No dependencies; imported by the interfaces, cqc_classify and the top level.
`timescale 1ns / 1ps

package cqc_pkg;

  // Agreeing call counters saturate at the maximum depth
  localparam int unsigned MAX_DEPTH = 1023;
  localparam int unsigned CNT_W     = $clog2(MAX_DEPTH + 1);
  // Wide enough for the sum of all four counters
  localparam int unsigned SUM_W     = CNT_W + 2;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DEPTH);

  // Threshold used while the register holds zero
  localparam logic [7:0] DEFAULT_HQ_THRESHOLD = 8'd30;

  // Character codes
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_GAP   = 8'h2D;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
  localparam logic [7:0] UPPER_MASK = 8'hDF;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned QUAL_W  = 8;
  localparam int unsigned CLASS_W = 5;

  localparam logic [CLASS_W-1:0] CLASS_NONE = '0;

  // Per-strand agreeing call counts of one slice
  typedef struct packed {
    logic [CNT_W-1:0] hq_fwd;
    logic [CNT_W-1:0] hq_rev;
    logic [CNT_W-1:0] lq_fwd;
    logic [CNT_W-1:0] lq_rev;
  } cqc_counts_t;

endpackage

// ----- design/cqc_if.sv -----
// Channel interfaces of the consensus quality classifier: base calls in,
// quality classes out, threshold register writes. Depends on cqc_pkg.
`timescale 1ns / 1ps

// One base call of a slice
interface cqc_call_if;
  import cqc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] consensus_char;
  logic [CHAR_W-1:0] base_char;
  logic [QUAL_W-1:0] base_quality;
  logic              strand;
  logic              last_base;
  logic              empty_slice;

  modport source (output valid, consensus_char, base_char, base_quality, strand,
                  last_base, empty_slice, input ready);
  modport sink   (input valid, consensus_char, base_char, base_quality, strand,
                  last_base, empty_slice, output ready);
endinterface

// One classification result
interface cqc_class_if;
  import cqc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] grade;

  modport source (output valid, grade, input ready);
  modport sink   (input valid, grade, output ready);
endinterface

// Threshold register write
interface cqc_cfg_if;
  import cqc_pkg::*;
  logic              valid;
  logic              ready;
  logic [QUAL_W-1:0] hq_level;

  modport source (output valid, hq_level, input ready);
  modport sink   (input valid, hq_level, output ready);
endinterface

// ----- design/cqc_classify.sv -----
// cqc_classify: derives the slice flags from the final counts and maps them
// through the priority rules to a quality class. Depends on cqc_pkg.
`timescale 1ns / 1ps

module cqc_classify (
  input  cqc_pkg::cqc_counts_t        counts,
  input  logic                        hq_conflict,
  input  logic                        lq_conflict,
  input  logic [cqc_pkg::CHAR_W-1:0]  consensus_char,
  output logic [cqc_pkg::CLASS_W-1:0] grade
);
  import cqc_pkg::*;

  logic [SUM_W-1:0] agree_sum;
  logic             known_cons;
  logic             hf, hr, lf, lr;
  logic             rev_dom, same_lq, other_lq;

  // Flags
  logic qual_other, conflict_free, qual_strand, nq_other, qual_same, nq_same;
  logic nq_conflict, single, nq_strand, qual_conflict, ambiguity, any_same, gap;

  assign hf = counts.hq_fwd != '0;
  assign hr = counts.hq_rev != '0;
  assign lf = counts.lq_fwd != '0;
  assign lr = counts.lq_rev != '0;

  assign agree_sum = SUM_W'(counts.hq_fwd) + SUM_W'(counts.hq_rev)
                   + SUM_W'(counts.lq_fwd) + SUM_W'(counts.lq_rev);

  assign known_cons = (consensus_char == CHAR_A) || (consensus_char == CHAR_C) ||
                      (consensus_char == CHAR_G) || (consensus_char == CHAR_T) ||
                      (consensus_char == CHAR_GAP);

  // Low quality support on the dominant and on the other strand
  assign rev_dom  = counts.hq_fwd < counts.hq_rev;
  assign same_lq  = rev_dom ? lr : lf;
  assign other_lq = rev_dom ? lf : lr;

  // Flag derivation
  always_comb begin
    conflict_free = !hq_conflict && !lq_conflict;
    single        = agree_sum == SUM_W'(1);
    ambiguity     = !known_cons;
    gap           = known_cons && (consensus_char == CHAR_GAP);
    qual_strand   = known_cons && (hf || hr);
    qual_other    = known_cons && hf && hr;
    qual_same     = known_cons && ((counts.hq_fwd > CNT_W'(1)) ||
                                   (counts.hq_rev > CNT_W'(1)));
    qual_conflict = hq_conflict;
    nq_conflict   = known_cons && !hq_conflict && lq_conflict;
    if (!known_cons) begin
      nq_strand = 1'b0;
      nq_other  = 1'b0;
      nq_same   = 1'b0;
    end else if (hf || hr) begin
      nq_strand = same_lq;
      nq_same   = same_lq;
      nq_other  = other_lq;
    end else begin
      nq_strand = lf || lr;
      nq_other  = lf && lr;
      nq_same   = (counts.lq_fwd > CNT_W'(1)) || (counts.lq_rev > CNT_W'(1));
    end
    any_same = nq_same || qual_same;
  end

  // Priority rules, first match wins
  always_comb begin
    if (gap && conflict_free)                              grade = 5'd21;
    else if (conflict_free && qual_other)                  grade = 5'd1;
    else if (conflict_free && qual_strand && nq_other)     grade = 5'd2;
    else if (conflict_free && qual_strand && any_same)     grade = 5'd3;
    else if (conflict_free && nq_other)                    grade = 5'd4;
    else if (conflict_free && nq_same)                     grade = 5'd5;
    else if (nq_conflict && qual_other)                    grade = 5'd6;
    else if (nq_conflict && qual_strand && nq_other)       grade = 5'd7;
    else if (nq_conflict && qual_strand && any_same)       grade = 5'd8;
    else if (conflict_free && qual_strand && single)       grade = 5'd9;
    else if (nq_conflict && nq_other)                      grade = 5'd10;
    else if (conflict_free && nq_strand && single)         grade = 5'd11;
    else if (nq_conflict && nq_same)                       grade = 5'd12;
    else if (nq_conflict && qual_strand && single)         grade = 5'd13;
    else if (nq_conflict && nq_strand && single)           grade = 5'd14;
    else if (qual_conflict && qual_other)                  grade = 5'd15;
    else if (qual_conflict && qual_strand && nq_other)     grade = 5'd16;
    else if (qual_conflict && qual_strand && any_same)     grade = 5'd17;
    else if (qual_conflict && nq_other)                    grade = 5'd18;
    else if (qual_conflict && nq_same)                     grade = 5'd19;
    else if (qual_conflict && qual_strand && single)       grade = 5'd20;
    else if (ambiguity && single)                          grade = 5'd21;
    else if (ambiguity)                                    grade = 5'd22;
    else if (qual_conflict && nq_strand && single)         grade = 5'd23;
    else if (!qual_strand && !nq_strand)                   grade = 5'd23;
    else                                                   grade = CLASS_NONE;
  end

endmodule

// ----- design/consensus_quality_classifier_top.sv -----
// consensus_quality_classifier_top: per-slice call counting and class output.
// Depends on cqc_pkg, the channel interfaces in cqc_if.sv and cqc_classify.
//
//   channel  direction  payload                                 use
//   calls    in         consensus/base char, quality, strand,   one base call
//                       last_base, empty_slice
//   classes  out        grade                                   one per slice
//   cfg      in         hq_level                                register write
//
// A call is taken every cycle unless a slice end is stalled; it is staged in
// the input register, where the counter update and, on a slice end, the
// classification are done, and the class is then registered in the output
// register. The counter read-modify-write sets the one-call-per-cycle rate.
// A waiting class stalls only a later slice end; middle calls keep flowing.
// Reset (rst, synchronous) clears counters, valids and the threshold.
`timescale 1ns / 1ps

module consensus_quality_classifier_top (
  input  logic         clk,
  input  logic         rst,
  cqc_call_if.sink     calls,
  cqc_class_if.source  classes,
  cqc_cfg_if.sink      cfg
);
  import cqc_pkg::*;

  // Threshold register
  logic [QUAL_W-1:0] hq_threshold;
  logic [QUAL_W-1:0] hq_limit;

  // Input register
  logic              s_valid;
  logic [CHAR_W-1:0] s_cons;
  logic [CHAR_W-1:0] s_base;
  logic [QUAL_W-1:0] s_qual;
  logic              s_strand;
  logic              s_last;
  logic              s_empty;

  // Slice state
  cqc_counts_t counts, counts_next;
  logic        hq_dis, hq_dis_next;
  logic        lq_dis, lq_dis_next;

  // Output register
  logic               o_valid;
  logic [CLASS_W-1:0] o_class;

  logic               produce, s_fire, accept;
  logic [CHAR_W-1:0]  base_up;
  logic               is_hq, matches_cons;
  logic [CLASS_W-1:0] class_calc;

  // Config writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hq_threshold <= '0;
    end else if (cfg.valid) begin
      hq_threshold <= cfg.hq_level;
    end
  end

  assign hq_limit = (hq_threshold == '0) ? DEFAULT_HQ_THRESHOLD : hq_threshold;

  // Flow control: the staged call advances unless it ends a slice while the
  // previous class is still waiting
  assign produce     = s_valid && (s_last || s_empty);
  assign s_fire      = s_valid && (!produce || !o_valid || classes.ready);
  assign calls.ready = !s_valid || s_fire;
  assign accept      = calls.valid && calls.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (calls.ready) begin
      s_valid <= calls.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_cons   <= calls.consensus_char;
      s_base   <= calls.base_char;
      s_qual   <= calls.base_quality;
      s_strand <= calls.strand;
      s_last   <= calls.last_base;
      s_empty  <= calls.empty_slice;
    end
  end

  // Fold lower case, compare, grade
  assign base_up      = ((s_base >= CHAR_LOW_A) && (s_base <= CHAR_LOW_Z)) ?
                        (s_base & UPPER_MASK) : s_base;
  assign matches_cons = base_up == s_cons;
  assign is_hq        = s_qual >= hq_limit;

  // Counter update, saturating
  always_comb begin
    counts_next = counts;
    hq_dis_next = hq_dis;
    lq_dis_next = lq_dis;
    if (matches_cons) begin
      case ({is_hq, s_strand})
        2'b11: if (counts.hq_rev != CNT_MAX) counts_next.hq_rev = counts.hq_rev + 1'b1;
        2'b10: if (counts.hq_fwd != CNT_MAX) counts_next.hq_fwd = counts.hq_fwd + 1'b1;
        2'b01: if (counts.lq_rev != CNT_MAX) counts_next.lq_rev = counts.lq_rev + 1'b1;
        2'b00: if (counts.lq_fwd != CNT_MAX) counts_next.lq_fwd = counts.lq_fwd + 1'b1;
        default: counts_next = counts;
      endcase
    end else if (is_hq) begin
      hq_dis_next = 1'b1;
    end else begin
      lq_dis_next = 1'b1;
    end
  end

  // Classification of the slice including the staged call
  cqc_classify u_classify (
    .counts         (counts_next),
    .hq_conflict    (hq_dis_next),
    .lq_conflict    (lq_dis_next),
    .consensus_char (s_cons),
    .grade          (class_calc)
  );

  // Slice state: cleared at every slice end or empty slice
  always_ff @(posedge clk) begin
    if (rst) begin
      counts <= '0;
      hq_dis <= 1'b0;
      lq_dis <= 1'b0;
    end else if (s_fire) begin
      if (produce) begin
        counts <= '0;
        hq_dis <= 1'b0;
        lq_dis <= 1'b0;
      end else begin
        counts <= counts_next;
        hq_dis <= hq_dis_next;
        lq_dis <= lq_dis_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s_fire && produce) begin
      o_valid <= 1'b1;
    end else if (classes.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && produce) begin
      o_class <= s_empty ? CLASS_NONE : class_calc;
    end
  end

  assign classes.valid = o_valid;
  assign classes.grade = o_class;

`ifndef SYNTHESIS
  // State is clean after a slice end
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    (s_fire && produce) |=> (counts == '0 && !hq_dis && !lq_dis))
    else $error("slice state not cleared after slice end");

  // Counters never pass the saturation value
  a_saturate: assert property (@(posedge clk) disable iff (rst)
    (counts.hq_fwd <= CNT_MAX) && (counts.hq_rev <= CNT_MAX) &&
    (counts.lq_fwd <= CNT_MAX) && (counts.lq_rev <= CNT_MAX))
    else $error("counter exceeded maximum depth");

  // An empty slice yields class zero on the next cycle
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_empty) |=> (o_valid && o_class == CLASS_NONE))
    else $error("empty slice did not give class zero");

  // Input is held off only by a slice end waiting on a full output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !calls.ready |-> (produce && o_valid && !classes.ready))
    else $error("input stalled without cause");

  // Class stays in range
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (o_class <= CLASS_W'(23)))
    else $error("quality class out of range");
`endif

endmodule
